FILE: rtl/hdm_pkg.sv
// hdm_pkg: payload structs, controller/datapath command and status types
// and fixed constants of the histogram difference motion detector.
// No dependencies.
package hdm_pkg;

	localparam int unsigned FIELD_W = 19;
	localparam logic [FIELD_W-1:0] FIELD_MAX = 19'h7FFFF;
	localparam logic [FIELD_W-1:0] THRESHOLD_RESET = 19'd850;
	localparam logic [7:0] PIXEL_RANGE = 8'd255;

	typedef struct packed {
		logic [7:0] pixel;
		logic       frame_end;
	} hdm_in_t;

	typedef struct packed {
		logic               motion;
		logic [FIELD_W-1:0] max_difference;
	} hdm_out_t;

	typedef struct packed {
		logic bin_en;
		logic bin_wr;
		logic sel;
		logic scan_start;
		logic scan_rd;
		logic load_out;
	} hdm_cmd_t;

	typedef struct packed {
		logic scan_last;
	} hdm_sts_t;

endpackage

FILE: rtl/hdm_ctrl.sv
// hdm_ctrl: controller state machine of the motion detector; sequences
// bin updates, the difference scan and result hand-off. Uses hdm_pkg.
module hdm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output hdm_pkg::hdm_cmd_t cmd,
	input  hdm_pkg::hdm_sts_t sts
);
	import hdm_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_WR    = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   phase_q, phase_d;
	logic   last_q;
	logic   out_valid_q, out_valid_d;
	logic   slot_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		out_valid_d = out_valid_q && out_stall;
		cmd         = '0;
		cmd.sel     = phase_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.bin_en = 1'b1;
					state_d    = ST_WR;
				end
			end
			ST_WR: begin
				cmd.bin_wr = 1'b1;
				state_d    = ST_IDLE;
				if (last_q) begin
					if (!phase_q) begin
						phase_d = 1'b1;
					end else begin
						cmd.scan_start = 1'b1;
						state_d        = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					out_valid_d  = 1'b1;
					phase_d      = 1'b0;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			phase_q     <= phase_d;
			out_valid_q <= out_valid_d;
			if (cmd.bin_en) begin
				last_q <= in_last;
			end
		end
	end

endmodule

FILE: rtl/hdm_datapath.sv
// hdm_datapath: bin index, two histogram RAMs with valid bits, saturating
// update, abs-difference max scan, threshold and result registers. Uses hdm_pkg.
module hdm_datapath #(
	parameter int BINS       = 64,
	parameter int COUNT_BITS = 19
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hdm_pkg::hdm_cmd_t           cmd,
	output hdm_pkg::hdm_sts_t           sts,
	input  logic [7:0]                  pixel,
	input  logic                        cfg_we,
	input  logic [hdm_pkg::FIELD_W-1:0] cfg_data,
	output hdm_pkg::hdm_out_t           out_data
);
	import hdm_pkg::*;

	localparam int BIN_W = $clog2(BINS);
	localparam int CMP_W = (COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W;

	logic [COUNT_BITS-1:0] hist_a [BINS];
	logic [COUNT_BITS-1:0] hist_b [BINS];
	logic [BINS-1:0]       vld_a_q, vld_b_q;

	logic [15:0]           prod;
	logic [16:0]           quo_sum;
	logic [7:0]            quo;
	logic                  skip;
	logic [BIN_W-1:0]      rd_addr;
	logic                  rd_en;

	logic [BIN_W-1:0]      bin_s1;
	logic                  skip_s1;
	logic [COUNT_BITS-1:0] rd_a_s1, rd_b_s1;
	logic                  va_s1, vb_s1;
	logic                  scan_s1;
	logic [COUNT_BITS-1:0] cnt_a, cnt_b, cur, inc, diff;

	logic [BIN_W-1:0]      scan_idx_q;
	logic [COUNT_BITS-1:0] max_q;
	logic [FIELD_W-1:0]    thr_q;
	hdm_out_t              out_q;

	// floor(x / 255) for x < 65280
	assign prod    = 16'(pixel) * 16'(BINS);
	assign quo_sum = 17'(prod) + 17'd1 + 17'(prod[15:8]);
	assign quo     = quo_sum[15:8];
	assign skip    = (quo >= 8'(BINS)) || (pixel == PIXEL_RANGE);
	assign rd_en   = cmd.bin_en || cmd.scan_rd;
	assign rd_addr = cmd.bin_en ? (skip ? '0 : quo[BIN_W-1:0]) : scan_idx_q;

	assign cnt_a = va_s1 ? rd_a_s1 : '0;
	assign cnt_b = vb_s1 ? rd_b_s1 : '0;
	assign cur   = cmd.sel ? cnt_b : cnt_a;
	assign inc   = (cur == '1) ? cur : cur + 1'b1;
	assign diff  = (cnt_a > cnt_b) ? (cnt_a - cnt_b) : (cnt_b - cnt_a);

	assign sts.scan_last = (scan_idx_q == BIN_W'(BINS - 1));
	assign out_data      = out_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a_s1 <= hist_a[rd_addr];
			rd_b_s1 <= hist_b[rd_addr];
		end
		if (cmd.bin_wr && !skip_s1) begin
			if (cmd.sel) begin
				hist_b[bin_s1] <= inc;
			end else begin
				hist_a[bin_s1] <= inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.bin_en) begin
			bin_s1  <= rd_addr;
			skip_s1 <= skip;
		end
		if (cmd.load_out) begin
			out_q.motion <= CMP_W'(max_q) > CMP_W'(thr_q);
			out_q.max_difference <= (CMP_W'(max_q) > CMP_W'(FIELD_MAX)) ?
				FIELD_MAX : FIELD_W'(max_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_a_q    <= '0;
			vld_b_q    <= '0;
			va_s1      <= 1'b0;
			vb_s1      <= 1'b0;
			scan_s1    <= 1'b0;
			scan_idx_q <= '0;
			max_q      <= '0;
			thr_q      <= THRESHOLD_RESET;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_data;
			end
			if (rd_en) begin
				va_s1 <= vld_a_q[rd_addr];
				vb_s1 <= vld_b_q[rd_addr];
			end
			if (cmd.bin_wr && !skip_s1) begin
				if (cmd.sel) begin
					vld_b_q[bin_s1] <= 1'b1;
				end else begin
					vld_a_q[bin_s1] <= 1'b1;
				end
			end
			if (cmd.load_out) begin
				vld_a_q <= '0;
				vld_b_q <= '0;
			end
			scan_s1 <= cmd.scan_rd;
			if (cmd.scan_start) begin
				scan_idx_q <= '0;
				max_q      <= '0;
			end else begin
				if (cmd.scan_rd) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
				if (scan_s1 && (diff > max_q)) begin
					max_q <= diff;
				end
			end
		end
	end

endmodule

FILE: rtl/histogram_difference_motion_detect.sv
// Histogram difference motion detector, top level.
// Joins hdm_ctrl and hdm_datapath; uses hdm_pkg.
//
// Usage:
//  - Input channel (in_valid/in_stall/in_data): one pixel per transfer with
//    a frame_end flag on the last pixel of each frame. Frames pair up: the
//    first frame of a pair fills one histogram, the second the other.
//  - Per pixel, the bin's RAM word is read, then written back incremented
//    (saturating). The input is stalled during the write-back.
//  - After the last pixel of the second frame the block scans all BINS bins,
//    one per cycle, and the result is then loaded into the output register.
//    The input is stalled during the scan.
//  - Output channel (out_valid/out_stall/out_data): one transfer per pair,
//    held in an output register. Pixels of the next pair are taken while it
//    waits; a new scan result waits in the controller until the slot frees.
//  - cfg_we/cfg_data write motion_threshold; write only while idle.
//  - Reset (arst_n low) clears both histograms, pair phase and the pending
//    result; the threshold returns to 850.
module histogram_difference_motion_detect #(
	parameter int BINS       = 64,
	parameter int COUNT_BITS = 19
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  hdm_pkg::hdm_in_t            in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output hdm_pkg::hdm_out_t           out_data,
	input  logic                        cfg_we,
	input  logic [hdm_pkg::FIELD_W-1:0] cfg_data
);
	import hdm_pkg::*;

	hdm_cmd_t cmd;
	hdm_sts_t sts;

	hdm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_last   (in_data.frame_end),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	hdm_datapath #(
		.BINS       (BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.pixel    (in_data.pixel),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.out_data (out_data)
	);

`ifndef SYNTH
	// one pixel in flight: the cycle after a transfer the input is stalled
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a pixel update is in flight");

	// a result only appears at the end of a scan, with the input stalled
	a_result_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall) && $past(in_stall, 2))
		else $error("result raised outside a scan");
`endif

endmodule

FILE: sim/tb_top.sv
// tb_top: self-checking bench for histogram_difference_motion_detect. Streams frame pairs with
// random idling on both channels and checks each motion report against a local histogram model.
// Depends on rtl/hdm_pkg.sv and rtl/histogram_difference_motion_detect.sv.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import hdm_pkg::*;

	localparam int HIST_BINS     = 64;
	localparam int COUNT_W       = 19;
	localparam int SETTLE_CYCLES = HIST_BINS + 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int ITEM_TARGET   = 1300;

	class motion_scoreboard;
		logic [COUNT_W-1:0] first_counts[HIST_BINS];
		logic [COUNT_W-1:0] second_counts[HIST_BINS];
		bit                 in_second;
		logic [FIELD_W-1:0] threshold;
		hdm_out_t           reports_due[$];
		int                 errors;
		int                 pixels;
		int                 reports;
		int                 motion_reports;

		function new();
			clear_counts();
			in_second = 1'b0;
			threshold = THRESHOLD_RESET;
			errors = 0;
			pixels = 0;
			reports = 0;
			motion_reports = 0;
		endfunction

		function void clear_counts();
			foreach (first_counts[i]) begin
				first_counts[i] = '0;
				second_counts[i] = '0;
			end
		endfunction

		function void set_threshold(logic [FIELD_W-1:0] value);
			threshold = value;
		endfunction

		function int pending();
			return reports_due.size();
		endfunction

		function void note_pixel(hdm_in_t xfer);
			int unsigned bin;
			int unsigned peak;
			int unsigned a;
			int unsigned b;
			int unsigned d;
			hdm_out_t    rpt;
			pixels++;
			// pixel 255 maps to bin HIST_BINS and is dropped
			bin = (int'(xfer.pixel) * HIST_BINS) / int'(PIXEL_RANGE);
			if (bin < HIST_BINS) begin
				if (!in_second) begin
					if (first_counts[bin] != '1)
						first_counts[bin]++;
				end else begin
					if (second_counts[bin] != '1)
						second_counts[bin]++;
				end
			end
			if (!xfer.frame_end)
				return;
			if (!in_second) begin
				in_second = 1'b1;
				return;
			end
			peak = 0;
			for (int i = 0; i < HIST_BINS; i++) begin
				a = 32'(first_counts[i]);
				b = 32'(second_counts[i]);
				d = (a > b) ? a - b : b - a;
				if (d > peak)
					peak = d;
			end
			rpt.motion = peak > threshold;
			rpt.max_difference = (peak > FIELD_MAX) ? FIELD_MAX : peak[FIELD_W-1:0];
			reports_due.push_back(rpt);
			if (rpt.motion)
				motion_reports++;
			clear_counts();
			in_second = 1'b0;
		endfunction

		function void check_report(hdm_out_t got);
			hdm_out_t want;
			if (reports_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected report, expected none, got motion=%0b max_difference=%0d",
					$time, got.motion, got.max_difference);
				return;
			end
			want = reports_due.pop_front();
			reports++;
			if (got.motion !== want.motion) begin
				errors++;
				$display("%0t: motion expected %0b, got %0b", $time, want.motion, got.motion);
			end
			if (got.max_difference !== want.max_difference) begin
				errors++;
				$display("%0t: max_difference expected %0d, got %0d",
					$time, want.max_difference, got.max_difference);
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	hdm_in_t            in_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	hdm_out_t           out_data;
	logic               cfg_we = 1'b0;
	logic [FIELD_W-1:0] cfg_data = '0;

	motion_scoreboard sb = new();

	int          cycles = 0;
	int          items_sent = 0;
	int          settings_used = 0;
	int          in_gap_odds = 0;
	bit          out_idle_on = 1'b0;
	int          stall_left = 0;
	int          free_left = 0;
	logic [7:0]  frame_px[$];

	histogram_difference_motion_detect #(
		.BINS(HIST_BINS),
		.COUNT_BITS(COUNT_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always #5ns clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: timeout after %0d cycles", cycles);
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// receiver back-pressure in bursts
	always @(posedge clk) begin
		if (!out_idle_on) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (free_left > 0) begin
			out_stall <= 1'b0;
			free_left--;
		end else begin
			out_stall <= 1'b0;
			free_left = ($urandom_range(7, 0) == 0) ? 100 : $urandom_range(20, 0);
			stall_left = $urandom_range(16, 1);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_report(out_data);
	end

	task automatic send_pixel(input logic [7:0] value, input logic last);
		hdm_in_t xfer;
		xfer.pixel = value;
		xfer.frame_end = last;
		if (in_gap_odds != 0 && $urandom_range(in_gap_odds - 1, 0) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(16, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= xfer;
		do @(posedge clk); while (in_stall);
		sb.note_pixel(xfer);
		items_sent++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_px.size(); i++)
			send_pixel(frame_px[i], i == frame_px.size() - 1);
	endtask

	task automatic write_threshold(input logic [FIELD_W-1:0] value);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_threshold(value);
		settings_used++;
	endtask

	function automatic logic [7:0] draw_pixel(input int mode, input logic [7:0] base);
		int v;
		case (mode)
			0: v = $urandom_range(255, 0);
			1: begin
				v = int'(base) + $urandom_range(3, 0);
				if (v > 255)
					v = 255;
			end
			2: v = $urandom_range(1, 0) ? 255 : $urandom_range(255, 0);
			default: begin
				case ($urandom_range(3, 0))
					0: v = 0;
					1: v = 1;
					2: v = 254;
					default: v = 255;
				endcase
			end
		endcase
		return v[7:0];
	endfunction

	task automatic random_frame();
		int         len;
		int         mode;
		logic [7:0] base;
		len = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
		mode = $urandom_range(3, 0);
		base = 8'($urandom_range(255, 0));
		frame_px.delete();
		repeat (len) frame_px.push_back(draw_pixel(mode, base));
		send_frame();
	endtask

	initial begin
		logic [FIELD_W-1:0] thr;
		int                 budget;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		in_gap_odds = 3;
		out_idle_on = 1'b1;

		// reset threshold; 255 dropped, bin edges 3/4 and 251/252/254
		frame_px = '{8'd0, 8'd255, 8'd3, 8'd4};
		send_frame();
		frame_px = '{8'd255};
		send_frame();
		frame_px = '{8'd251, 8'd252, 8'd254};
		send_frame();
		frame_px = '{8'd252, 8'd128};
		send_frame();
		frame_px = '{8'd255};
		send_frame();
		send_frame();
		frame_px = '{8'd7, 8'd7};
		send_frame();
		send_frame();

		// zero threshold: equal histograms no motion, one count apart motion
		write_threshold('0);
		frame_px = '{8'd1};
		send_frame();
		frame_px = '{8'd2};
		send_frame();
		frame_px = '{8'd1};
		send_frame();
		frame_px = '{8'd200};
		send_frame();

		write_threshold(FIELD_MAX);
		frame_px = '{8'd0, 8'd0, 8'd0};
		send_frame();
		frame_px = '{8'd255};
		send_frame();

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: thr = FIELD_W'(5);
				1: thr = THRESHOLD_RESET;
				2: thr = '0;
				3: thr = FIELD_W'($urandom_range(30, 0));
				4: thr = FIELD_MAX;
				5: thr = FIELD_W'(1);
				6: thr = FIELD_W'($urandom_range(12, 0));
				default: thr = FIELD_W'(3);
			endcase
			write_threshold(thr);
			in_gap_odds = (p == 7) ? 0 : ((p % 2 == 0) ? 4 : 12);
			out_idle_on = (p != 7);
			budget = 24 + (ITEM_TARGET - 24) * (p + 1) / 8;
			while (items_sent < budget) begin
				random_frame();
				random_frame();
			end
		end

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("tb_top: %0d pixels streamed, %0d frame pairs reported, %0d with motion",
			sb.pixels, sb.reports, sb.motion_reports);
		$display("tb_top: %0d threshold settings, from 0 up to %0d", settings_used, FIELD_MAX);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/hdm_pkg.sv
rtl/hdm_ctrl.sv
rtl/hdm_datapath.sv
rtl/histogram_difference_motion_detect.sv
sim/tb_top.sv
